>>> rtl/core/lzss_pkg.sv
// Shared constants and types for the LZSS ring-window decompressor.
// No dependencies; used by lzss_window_decompressor.
package lzss_pkg;

	// Ring window geometry
	localparam int WIN_DEPTH = 4096;
	localparam int WIN_AW = $clog2(WIN_DEPTH);
	localparam logic [WIN_AW-1:0] WP_RESET = WIN_AW'(WIN_DEPTH - 16);
	localparam logic [7:0] FILL_BYTE = 8'h20;

	// Match encoding
	localparam logic [4:0] MATCH_MIN = 5'd3;

	// Result status codes
	localparam logic [1:0] ST_RUN = 2'd0;
	localparam logic [1:0] ST_SIZE = 2'd1;
	localparam logic [1:0] ST_TRUNC = 2'd2;

	// One result as held in the output register
	typedef struct packed {
		logic [1:0] status;
		logic       byte_valid;
		logic       last;
		logic [7:0] out_byte;
	} result_t;

endpackage

>>> rtl/core/lzss_window_decompressor.sv
// LZSS decompressor with a 4096-byte space-filled ring window, one request byte at a time.
// Depends on lzss_pkg (window geometry, status codes, result type).
//
// Sequencing: a control or match-low byte passes through decode only; a literal adds a
// write step; a match (up to 18 bytes) adds a window read and write-back per copied byte.
// Input waits until a byte is done; results leave through a registered output stage.
// Reset: asynchronous, active low; the window reads as spaces through a fill count, so no
// clearing pass is needed and requests are taken right after reset.
module lzss_window_decompressor (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration: unpacked size
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,     // out_length
	// Compressed bytes in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,      // [7:0] data_byte
	input  logic        s_tlast,      // end_of_input
	// Decompressed results out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,      // [7:0] out_byte
	output logic        m_tlast,      // last
	output logic [2:0]  m_tuser       // [0] byte_valid, [2:1] status
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEC  = 3'd1;
	localparam logic [2:0] S_LIT  = 3'd2;
	localparam logic [2:0] S_RD   = 3'd3;
	localparam logic [2:0] S_WR   = 3'd4;
	localparam logic [2:0] S_STAT = 3'd5;

	logic [2:0]                  state_q;
	logic [31:0]                 out_length_q;
	logic [7:0]                  data_q;
	logic                        eoi_q;
	logic [lzss_pkg::WIN_AW-1:0] wp_q;
	logic [lzss_pkg::WIN_AW:0]   fill_q;
	logic [7:0]                  ctrl_q;
	logic [3:0]                  idx_q;
	logic [7:0]                  low_q;
	logic                        await_hi_q;
	logic [31:0]                 produced_q;
	logic                        finished_q;
	logic [lzss_pkg::WIN_AW-1:0] pos_q;
	logic [4:0]                  len_q;
	logic [1:0]                  stat_q;
	logic                        rd_ok_q;
	logic [7:0]                  rdata_q;
	lzss_pkg::result_t           res_q;
	logic                        res_valid_q;

	logic [7:0] win_mem [lzss_pkg::WIN_DEPTH];

	logic                        out_free;
	logic                        res_load;
	logic                        size_met;
	logic                        size_hit;
	logic [32:0]                 prod_inc;
	logic                        win_we;
	logic                        win_re;
	logic [7:0]                  wr_byte;
	logic [7:0]                  copy_byte;
	logic [lzss_pkg::WIN_AW-1:0] rd_off;
	logic                        rd_ok;
	logic                        last_copy;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == S_IDLE);
	assign m_tvalid  = res_valid_q;
	assign m_tdata   = res_q.out_byte;
	assign m_tlast   = res_q.last;
	assign m_tuser   = {res_q.status, res_q.byte_valid};

	// Output slot frees when empty or being taken
	assign out_free  = !res_valid_q || m_tready;
	assign res_load  = out_free &&
	                   ((state_q == S_LIT) || (state_q == S_WR) || (state_q == S_STAT));
	assign size_met  = produced_q >= out_length_q;
	assign prod_inc  = {1'b0, produced_q} + 33'd1;
	assign size_hit  = prod_inc >= {1'b0, out_length_q};
	assign last_copy = (len_q == 5'd1);

	// Entries the write pointer has not reached yet still hold spaces
	assign rd_off    = pos_q - lzss_pkg::WP_RESET;
	assign rd_ok     = {1'b0, rd_off} < fill_q;
	assign copy_byte = rd_ok_q ? rdata_q : lzss_pkg::FILL_BYTE;

	assign win_re  = (state_q == S_RD);
	assign win_we  = ((state_q == S_LIT) || (state_q == S_WR)) && out_free;
	assign wr_byte = (state_q == S_LIT) ? data_q : copy_byte;

	// Window memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (win_we) begin
			win_mem[wp_q] <= wr_byte;
		end
		if (win_re) begin
			rdata_q <= win_mem[pos_q];
		end
	end

	// Sequencer and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_length_q <= '0;
			data_q       <= '0;
			eoi_q        <= 1'b0;
			wp_q         <= lzss_pkg::WP_RESET;
			fill_q       <= '0;
			ctrl_q       <= '0;
			idx_q        <= 4'd8;
			low_q        <= '0;
			await_hi_q   <= 1'b0;
			produced_q   <= '0;
			finished_q   <= 1'b0;
			pos_q        <= '0;
			len_q        <= '0;
			stat_q       <= lzss_pkg::ST_RUN;
			rd_ok_q      <= 1'b0;
			res_q        <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				out_length_q <= cfg_data;
			end

			// Drop the result once taken, unless a new one loads this cycle
			if (res_valid_q && m_tready && !res_load) begin
				res_valid_q <= 1'b0;
			end

			// Advance window pointer and counts on every written byte
			if (win_we) begin
				wp_q       <= wp_q + 1'b1;
				produced_q <= prod_inc[31:0];
				if (fill_q < (lzss_pkg::WIN_AW + 1)'(lzss_pkg::WIN_DEPTH)) begin
					fill_q <= fill_q + 1'b1;
				end
			end

			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						data_q  <= s_tdata;
						eoi_q   <= s_tlast;
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					if (finished_q) begin
						stat_q  <= size_met ? lzss_pkg::ST_SIZE : lzss_pkg::ST_TRUNC;
						state_q <= S_STAT;
					end else if (size_met) begin
						finished_q <= 1'b1;
						stat_q     <= lzss_pkg::ST_SIZE;
						state_q    <= S_STAT;
					end else if (!idx_q[3] && ctrl_q[idx_q[2:0]]) begin
						state_q <= S_LIT;
					end else if (!idx_q[3] && await_hi_q) begin
						pos_q      <= {data_q[7:4], low_q};
						len_q      <= {1'b0, data_q[3:0]} + lzss_pkg::MATCH_MIN;
						await_hi_q <= 1'b0;
						idx_q      <= idx_q + 4'd1;
						state_q    <= S_RD;
					end else begin
						// Control byte or match low byte: no output of its own
						if (idx_q[3]) begin
							ctrl_q <= data_q;
							idx_q  <= 4'd0;
						end else begin
							low_q      <= data_q;
							await_hi_q <= 1'b1;
						end
						if (eoi_q) begin
							finished_q <= 1'b1;
							stat_q     <= lzss_pkg::ST_TRUNC;
							state_q    <= S_STAT;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_LIT: begin
					if (out_free) begin
						res_valid_q      <= 1'b1;
						res_q.out_byte   <= data_q;
						res_q.byte_valid <= 1'b1;
						res_q.last       <= 1'b1;
						res_q.status     <= size_hit ? lzss_pkg::ST_SIZE :
						                    eoi_q ? lzss_pkg::ST_TRUNC : lzss_pkg::ST_RUN;
						finished_q       <= size_hit || eoi_q;
						idx_q            <= idx_q + 4'd1;
						state_q          <= S_IDLE;
					end
				end
				S_RD: begin
					rd_ok_q <= rd_ok;
					pos_q   <= pos_q + 1'b1;
					state_q <= S_WR;
				end
				S_WR: begin
					if (out_free) begin
						res_valid_q      <= 1'b1;
						res_q.out_byte   <= copy_byte;
						res_q.byte_valid <= 1'b1;
						res_q.last       <= size_hit || last_copy;
						res_q.status     <= size_hit ? lzss_pkg::ST_SIZE :
						                    (last_copy && eoi_q) ? lzss_pkg::ST_TRUNC :
						                    lzss_pkg::ST_RUN;
						len_q            <= len_q - 5'd1;
						if (size_hit || last_copy) begin
							finished_q <= size_hit || eoi_q;
							state_q    <= S_IDLE;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_STAT: begin
					if (out_free) begin
						res_valid_q      <= 1'b1;
						res_q.out_byte   <= '0;
						res_q.byte_valid <= 1'b0;
						res_q.last       <= 1'b1;
						res_q.status     <= stat_q;
						state_q          <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Status-only results always close a request
	a_stat_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> m_tlast)
		else $error("status-only result without last");

	// Once finished, the block stays finished until reset
	a_fin_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q |=> finished_q)
		else $error("finished flag cleared");

	// A window read is always followed by its write-back step
	a_rd_wr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD) |=> (state_q == S_WR))
		else $error("window read not followed by write step");

	// Fill count never passes the window depth
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= (lzss_pkg::WIN_AW + 1)'(lzss_pkg::WIN_DEPTH))
		else $error("fill count overrun");

endmodule
